// File: rtl/ihex_pkg.sv
// Shared types, constants and character helpers for the Intel HEX record encoder.
// No dependencies.
package ihex_pkg;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_FLUSH  = 2'd1,
        OP_FINISH = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        CH_COLON,
        CH_HI,
        CH_LO,
        CH_NL,
        CH_EOF
    } char_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_WRITE,
        S_COLON,
        S_BYTE_HI,
        S_BYTE_LO,
        S_NL,
        S_EOF
    } state_t;

    typedef enum logic [1:0] {
        PH_BREAK,
        PH_FULL,
        PH_FLUSH
    } phase_t;

    typedef struct packed {
        logic      load_item;
        logic      restart;
        logic      write_byte;
        logic      finish_full;
        logic      clear_rec;
        logic      clr_pos;
        logic      emit;
        logic      emit_last;
        char_sel_t sel;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic brk;
        logic pending;
        logic full_next;
        logic len_one;
        logic last_byte;
        logic eof_end;
        logic out_free;
    } dp_stat_t;

    localparam logic [4:0] CFG_RESET = 5'd16;
    localparam logic [7:0] CHR_COLON = 8'h3A;
    localparam logic [7:0] CHR_NL    = 8'h0A;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_ONE   = 8'h31;
    localparam logic [7:0] CHR_F     = 8'h46;
    localparam logic [3:0] EOF_LAST  = 4'd11;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        if (v < 4'd10)
            return CHR_ZERO + {4'h0, v};
        else
            return 8'h37 + {4'h0, v};
    endfunction

    // ":00000001FF\n"
    function automatic logic [7:0] eof_char(input logic [3:0] i);
        case (i)
            4'd0:    return CHR_COLON;
            4'd8:    return CHR_ONE;
            4'd9:    return CHR_F;
            4'd10:   return CHR_F;
            4'd11:   return CHR_NL;
            default: return CHR_ZERO;
        endcase
    endfunction

endpackage

// File: rtl/intel_hex_record_encoder.sv
// Intel HEX record encoder: one item in flight. An add item that closes a record emits
// it one output character per cycle from the output register while the output is not
// stalled, with no idle controller states between characters.
// A finish item adds the end record. Output stalls hold the sequencer.
// Reset (rst_n, async low) clears the pending record and sets bytes_per_line to 16;
// the line buffer is not cleared. Depends on ihex_pkg, ihex_ctrl, ihex_dp.
module intel_hex_record_encoder #(
    parameter int MAX_LINE_BYTES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [15:0] address,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  text_char,
    output logic        last,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data
);
    import ihex_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ihex_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ihex_dp #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .operation   (operation),
        .address     (address),
        .data_byte   (data_byte),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .text_char   (text_char),
        .last        (last),
        .cmd         (cmd),
        .stat        (stat)
    );
endmodule

// File: rtl/ihex_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ihex_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        if (re)
            rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: rtl/ihex_ctrl.sv
// Controller state machine: sequences record checks, buffer writes and character output.
// Depends on ihex_pkg.
module ihex_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ihex_pkg::dp_stat_t stat,
    output ihex_pkg::dp_cmd_t  cmd
);
    import ihex_pkg::*;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_FLUSH;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                case (stat.op)
                    OP_ADD:
                    begin
                        if (stat.brk && stat.pending)
                        begin
                            phase_next = PH_BREAK;
                            state_next = S_COLON;
                        end
                        else
                            state_next = S_WRITE;
                    end
                    OP_FLUSH, OP_FINISH:
                    begin
                        if (stat.pending)
                        begin
                            phase_next = PH_FLUSH;
                            state_next = S_COLON;
                        end
                        else if (stat.op == OP_FINISH)
                            state_next = S_EOF;
                        else
                            state_next = S_IDLE;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_WRITE:
            begin
                if (stat.full_next)
                begin
                    phase_next = PH_FULL;
                    state_next = S_COLON;
                end
                else
                    state_next = S_IDLE;
            end
            S_COLON:
            begin
                if (stat.out_free)
                    state_next = S_BYTE_HI;
            end
            S_BYTE_HI:
            begin
                if (stat.out_free)
                    state_next = S_BYTE_LO;
            end
            S_BYTE_LO:
            begin
                if (stat.out_free)
                    state_next = stat.last_byte ? S_NL : S_BYTE_HI;
            end
            S_NL:
            begin
                if (stat.out_free)
                begin
                    case (phase_reg)
                        PH_BREAK: state_next = S_WRITE;
                        PH_FULL:  state_next = S_IDLE;
                        default:  state_next = (stat.op == OP_FINISH) ? S_EOF : S_IDLE;
                    endcase
                end
            end
            S_EOF:
            begin
                if (stat.out_free && stat.eof_end)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.sel  = CH_COLON;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            S_CHECK:
            begin
                cmd.clr_pos = 1'b1;
                if (stat.op == OP_ADD)
                    cmd.restart = stat.brk && !stat.pending;
                else if (stat.op == OP_FLUSH || stat.op == OP_FINISH)
                    cmd.clear_rec = !stat.pending;
            end
            S_WRITE:
            begin
                cmd.clr_pos    = 1'b1;
                cmd.write_byte = 1'b1;
            end
            S_COLON:
            begin
                cmd.emit = 1'b1;
                cmd.sel  = CH_COLON;
            end
            S_BYTE_HI:
            begin
                cmd.emit = 1'b1;
                cmd.sel  = CH_HI;
            end
            S_BYTE_LO:
            begin
                cmd.emit = 1'b1;
                cmd.sel  = CH_LO;
            end
            S_NL:
            begin
                cmd.emit    = 1'b1;
                cmd.sel     = CH_NL;
                cmd.clr_pos = 1'b1;
                case (phase_reg)
                    PH_BREAK:
                    begin
                        cmd.emit_last = !stat.len_one;
                        cmd.restart   = stat.out_free;
                    end
                    PH_FULL:
                    begin
                        cmd.emit_last   = 1'b1;
                        cmd.finish_full = stat.out_free;
                    end
                    default:
                    begin
                        cmd.emit_last = (stat.op != OP_FINISH);
                        cmd.clear_rec = stat.out_free;
                    end
                endcase
            end
            S_EOF:
            begin
                cmd.emit      = 1'b1;
                cmd.sel       = CH_EOF;
                cmd.emit_last = stat.eof_end;
            end
            default: cmd = '0;
        endcase
    end
endmodule

// File: rtl/ihex_dp.sv
// Datapath: item registers, record state, line buffer, checksum and output register.
// Depends on ihex_pkg and ihex_ram.
module ihex_dp #(
    parameter int MAX_LINE_BYTES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         operation,
    input  logic [15:0]        address,
    input  logic [7:0]         data_byte,
    input  logic               cfg_wr_en,
    input  logic [4:0]         cfg_wr_data,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [7:0]         text_char,
    output logic               last,
    input  ihex_pkg::dp_cmd_t  cmd,
    output ihex_pkg::dp_stat_t stat
);
    import ihex_pkg::*;

    localparam int CW = $clog2(MAX_LINE_BYTES + 1);
    localparam int AW = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;
    localparam int PW = $clog2(MAX_LINE_BYTES + 13);

    op_t           op_reg;
    logic [15:0]   addr_reg;
    logic [7:0]    byte_reg;
    logic [15:0]   start_reg, start_next;
    logic [CW-1:0] count_reg, count_next;
    logic [4:0]    cfg_reg;
    logic [PW-1:0] pos_reg, pos_next;
    logic [7:0]    sum_reg, sum_next;
    logic [7:0]    char_reg, char_next;
    logic          last_reg;
    logic          out_valid_reg, out_valid_next;

    logic [CW-1:0] len;
    logic [CW-1:0] count_inc;
    logic [PW-1:0] rec_end;
    logic [PW-1:0] rd_idx;
    logic [7:0]    cur_byte;
    logic [7:0]    rd_data;
    logic          out_free;
    logic          emit_fire;
    logic          next_data;
    logic          rd_en;

    always_comb
    begin
        if (cfg_reg == 5'd0)
            len = CW'(1);
        else if (int'(cfg_reg) > MAX_LINE_BYTES)
            len = CW'(MAX_LINE_BYTES);
        else
            len = CW'(cfg_reg);
    end

    assign count_inc = count_reg + CW'(1);
    assign rec_end   = PW'(4) + PW'(count_reg);
    assign rd_idx    = pos_reg - PW'(3);
    assign out_free  = !out_valid_reg || out_ready;
    assign emit_fire = cmd.emit && out_free;
    assign next_data = (pos_reg >= PW'(3)) && (pos_reg < rec_end - PW'(1));
    assign rd_en     = emit_fire && (cmd.sel == CH_LO) && next_data;

    always_comb
    begin
        if (pos_reg == PW'(0))
            cur_byte = 8'(count_reg);
        else if (pos_reg == PW'(1))
            cur_byte = start_reg[15:8];
        else if (pos_reg == PW'(2))
            cur_byte = start_reg[7:0];
        else if (pos_reg == PW'(3))
            cur_byte = 8'h00;
        else if (pos_reg < rec_end)
            cur_byte = rd_data;
        else
            cur_byte = (~sum_reg) + 8'd1;
    end

    always_comb
    begin
        case (cmd.sel)
            CH_COLON: char_next = CHR_COLON;
            CH_HI:    char_next = hex_digit(cur_byte[7:4]);
            CH_LO:    char_next = hex_digit(cur_byte[3:0]);
            CH_NL:    char_next = CHR_NL;
            CH_EOF:   char_next = eof_char(pos_reg[3:0]);
            default:  char_next = CHR_NL;
        endcase
    end

    always_comb
    begin
        start_next = start_reg;
        count_next = count_reg;
        if (cmd.restart)
        begin
            start_next = addr_reg;
            count_next = '0;
        end
        else if (cmd.write_byte)
            count_next = count_inc;
        else if (cmd.finish_full)
        begin
            start_next = addr_reg + 16'd1;
            count_next = '0;
        end
        else if (cmd.clear_rec)
        begin
            start_next = '0;
            count_next = '0;
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        if (cmd.clr_pos)
        begin
            pos_next = '0;
            sum_next = '0;
        end
        else if (emit_fire && cmd.sel == CH_LO)
        begin
            pos_next = pos_reg + PW'(1);
            sum_next = sum_reg + cur_byte;
        end
        else if (emit_fire && cmd.sel == CH_EOF)
            pos_next = pos_reg + PW'(1);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit_fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg     <= '0;
            count_reg     <= '0;
            cfg_reg       <= CFG_RESET;
            pos_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg     <= start_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                cfg_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg   <= op_t'(operation);
            addr_reg <= address;
            byte_reg <= data_byte;
        end
        if (emit_fire)
        begin
            char_reg <= char_next;
            last_reg <= cmd.emit_last;
        end
    end

    ihex_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LINE_BYTES)
    ) u_line_buf (
        .clk   (clk),
        .we    (cmd.write_byte),
        .waddr (count_reg[AW-1:0]),
        .wdata (byte_reg),
        .re    (rd_en),
        .raddr (rd_idx[AW-1:0]),
        .rdata (rd_data)
    );

    always_comb
    begin
        stat.op        = op_reg;
        stat.brk       = ({1'b0, start_reg} + 17'(count_reg)) != {1'b0, addr_reg};
        stat.pending   = (count_reg != '0);
        stat.full_next = (count_inc >= len);
        stat.len_one   = (len == CW'(1));
        stat.last_byte = (pos_reg == rec_end);
        stat.eof_end   = (pos_reg == PW'(EOF_LAST));
        stat.out_free  = out_free;
    end

    assign out_valid = out_valid_reg;
    assign text_char = char_reg;
    assign last      = last_reg;
endmodule

// File: rtl/ihex_checker.sv
// Port-level checks for the Intel HEX record encoder, bound to the top level.
// Depends on intel_hex_record_encoder.
module ihex_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] text_char,
    input logic       last
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(text_char) && $stable(last))
        else $error("output item changed while stalled");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while an item is in progress");

    a_last_nl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> text_char == 8'h0A)
        else $error("last flag on a character other than newline");

    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (text_char >= 8'h30 && text_char <= 8'h39) ||
                      (text_char >= 8'h41 && text_char <= 8'h46) ||
                      text_char == 8'h3A || text_char == 8'h0A)
        else $error("character outside the record alphabet");
endmodule

bind intel_hex_record_encoder ihex_checker u_ihex_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .text_char (text_char),
    .last      (last)
);
